// File: hw/rtl/light_alarm_code_controller_macros.svh
// Assertion macros shared by the light, alarm and code entry controller.
// Used by files that include this header; no other dependencies.
`ifndef LIGHT_ALARM_CODE_CONTROLLER_MACROS_SVH
`define LIGHT_ALARM_CODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LACC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lacc_pkg.sv
// Shared types and constants for the light, alarm and code entry controller.
// No dependencies; every RTL module file imports this package.
package lacc_pkg;

	localparam int CODE_DIGITS = 3;
	localparam int IDX_W       = 2;
	localparam int DIGIT_W     = 4;
	localparam int TICK_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;

	typedef logic [DIGIT_W-1:0]             digit_t;
	typedef logic [TICK_W-1:0]              tick_t;
	typedef logic [IDX_W-1:0]               idx_t;
	typedef digit_t [CODE_DIGITS-1:0]       key_t;

	localparam idx_t LAST_IDX = IDX_W'(CODE_DIGITS - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_HOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_GAP  = 3'd4;

	localparam digit_t KEY_FIRST_RST  = 4'd6;
	localparam digit_t KEY_SECOND_RST = 4'd3;
	localparam digit_t KEY_THIRD_RST  = 4'd5;
	localparam tick_t  LIGHT_HOLD_RST = 8'd60;
	localparam tick_t  DIGIT_GAP_RST  = 8'd3;

	typedef struct packed {
		logic presence_seen;
		logic button_pressed;
		logic start_request;
		logic digit_press;
	} item_t;

	typedef struct packed {
		logic       light_on;
		logic       alarm_armed;
		logic       siren_on;
		logic       entering_code;
		logic [1:0] digit_position;
		logic       code_accepted;
	} result_t;

	// one step strobe plus the event word it applies
	typedef struct packed {
		logic  fire;
		item_t item;
	} step_t;

	// end of a code entry, reported from the entry machine to the alarm
	typedef struct packed {
		logic done;
		logic match;
	} entry_event_t;

endpackage

// File: hw/rtl/lacc_light.sv
// Light machine: latched presence and button flags plus the hold countdown.
// Depends on lacc_pkg.
module lacc_light (
	input  logic            clk,
	input  logic            arst_n,
	input  lacc_pkg::step_t step,
	input  lacc_pkg::tick_t hold,
	output logic            light_on
);
	import lacc_pkg::*;

	logic  on_q, pres_q, btn_q;
	tick_t cd_q;
	logic  on_d, pres_d, btn_d;
	tick_t cd_d;
	logic  pres, btn;
	tick_t cd_dec;

	always_comb begin
		pres   = pres_q | step.item.presence_seen;
		btn    = btn_q | step.item.button_pressed;
		cd_dec = (cd_q != '0) ? cd_q - 1'b1 : cd_q;
		on_d   = on_q;
		pres_d = pres;
		btn_d  = btn;
		cd_d   = cd_dec;
		if (!on_q) begin
			if (pres || btn) begin
				on_d   = 1'b1;
				cd_d   = hold;
				pres_d = 1'b0;
				btn_d  = 1'b0;
			end
		end else if (pres && !btn) begin
			cd_d   = hold;
			pres_d = 1'b0;
		end else if (btn || cd_dec == '0) begin
			on_d  = 1'b0;
			btn_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q   <= 1'b0;
			pres_q <= 1'b0;
			btn_q  <= 1'b0;
			cd_q   <= '0;
		end else if (step.fire) begin
			on_q   <= on_d;
			pres_q <= pres_d;
			btn_q  <= btn_d;
			cd_q   <= cd_d;
		end
	end

	assign light_on = on_q;

endmodule

// File: hw/rtl/lacc_entry.sv
// Code entry machine: digit registers, index, gap countdown and key compare.
// Depends on lacc_pkg.
module lacc_entry (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lacc_pkg::step_t        step,
	input  lacc_pkg::tick_t        gap,
	input  lacc_pkg::key_t         key,
	output logic                   entering,
	output lacc_pkg::idx_t         position,
	output lacc_pkg::entry_event_t evt
);
	import lacc_pkg::*;

	logic  mode_q, start_q, dig_q, pb_q;
	idx_t  idx_q;
	tick_t cd_q;
	key_t  digits_q;
	logic  mode_d, start_d, dig_d, pb_d;
	idx_t  idx_d;
	tick_t cd_d;
	key_t  digits_d;
	logic  start, dig, expired, press, advance_idx, finish, match;
	tick_t cd_dec;

	function automatic digit_t inc_mod10(input digit_t d);
		return (d >= 4'd9) ? '0 : d + 1'b1;
	endfunction

	always_comb begin
		match = 1'b1;
		for (int k = 0; k < CODE_DIGITS; k++) begin
			if (digits_q[k] != key[k]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		start       = start_q | step.item.start_request;
		dig         = dig_q | step.item.digit_press;
		cd_dec      = (cd_q != '0) ? cd_q - 1'b1 : cd_q;
		expired     = (cd_dec == '0);
		press       = mode_q && idx_q <= LAST_IDX && dig;
		advance_idx = mode_q && !press && idx_q < LAST_IDX && expired && pb_q;
		finish      = mode_q && !press && !advance_idx && idx_q >= LAST_IDX && expired;

		mode_d   = mode_q;
		start_d  = start;
		dig_d    = dig;
		pb_d     = pb_q;
		idx_d    = idx_q;
		cd_d     = cd_dec;
		digits_d = digits_q;
		if (!mode_q && start) begin
			mode_d = 1'b1;
		end
		if (press) begin
			for (int k = 0; k < CODE_DIGITS; k++) begin
				if (idx_q == IDX_W'(k)) begin
					digits_d[k] = inc_mod10(digits_q[k]);
				end
			end
			cd_d  = gap;
			pb_d  = 1'b1;
			dig_d = 1'b0;
		end
		if (advance_idx) begin
			cd_d  = gap;
			idx_d = idx_q + 1'b1;
			pb_d  = 1'b0;
		end
		if (finish) begin
			start_d  = 1'b0;
			digits_d = '0;
			idx_d    = '0;
			mode_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			start_q  <= 1'b0;
			dig_q    <= 1'b0;
			pb_q     <= 1'b0;
			idx_q    <= '0;
			cd_q     <= '0;
			digits_q <= '0;
		end else if (step.fire) begin
			mode_q   <= mode_d;
			start_q  <= start_d;
			dig_q    <= dig_d;
			pb_q     <= pb_d;
			idx_q    <= idx_d;
			cd_q     <= cd_d;
			digits_q <= digits_d;
		end
	end

	assign entering  = mode_q;
	assign position  = idx_q;
	assign evt.done  = finish;
	assign evt.match = match;

endmodule

// File: hw/rtl/lacc_alarm.sv
// Alarm machine: armed state, siren, siren presence flag and pending code ok.
// Depends on lacc_pkg; takes the end-of-entry event from lacc_entry.
module lacc_alarm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lacc_pkg::step_t        step,
	input  lacc_pkg::entry_event_t evt,
	output logic                   armed,
	output logic                   siren,
	output logic                   code_ok
);
	import lacc_pkg::*;

	logic armed_q, siren_q, ok_q, pres_q;
	logic armed_d, siren_d, ok_d, pres_d;
	logic pres;

	always_comb begin
		pres    = pres_q | step.item.presence_seen;
		armed_d = armed_q;
		siren_d = siren_q;
		ok_d    = ok_q;
		pres_d  = pres;
		if (!armed_q) begin
			if (ok_q) begin
				armed_d = 1'b1;
				ok_d    = 1'b0;
				pres_d  = 1'b0;
			end
		end else if (pres && !ok_q) begin
			siren_d = 1'b1;
			pres_d  = 1'b0;
		end else if (ok_q) begin
			armed_d = 1'b0;
			ok_d    = 1'b0;
			siren_d = 1'b0;
		end
		// entry runs after the alarm, so its verdict overrides
		if (evt.done) begin
			ok_d = evt.match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			siren_q <= 1'b0;
			ok_q    <= 1'b0;
			pres_q  <= 1'b0;
		end else if (step.fire) begin
			armed_q <= armed_d;
			siren_q <= siren_d;
			ok_q    <= ok_d;
			pres_q  <= pres_d;
		end
	end

	assign armed   = armed_q;
	assign siren   = siren_q;
	assign code_ok = ok_q;

endmodule

// File: hw/rtl/light_alarm_code_controller.sv
// Channel  | Dir | Handshake              | Payload
// item     | in  | item_valid/item_ready  | lacc_pkg::item_t (four event flags)
// result   | out | result_valid/result_ready | lacc_pkg::result_t (state after step)
// cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One word per cycle sustained while result_ready stays high.
// A word sits in the input stage, then one step of all three machines updates
// the state registers, which also serve as the result register.
// The input stage keeps taking words while a result waits, one deep.
// Reset clears state to all machines idle and loads the default key and timers.
// Top level of the light, alarm and code entry controller.
// Depends on lacc_pkg, lacc_light, lacc_alarm, lacc_entry and the macros header.
`include "light_alarm_code_controller_macros.svh"

module light_alarm_code_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lacc_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lacc_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lacc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lacc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lacc_pkg::*;

	logic         valid_s1;
	item_t        item_s1;
	logic         result_valid_q;
	logic         advance;
	step_t        step;
	key_t         key_q;
	tick_t        hold_q, gap_q;
	entry_event_t evt;
	logic         light_on, armed, siren, code_ok, entering;
	idx_t         position;

	// step the machines once the result slot is free or being drained
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;
	assign step.fire  = advance;
	assign step.item  = item_s1;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= KEY_FIRST_RST;
			key_q[1] <= KEY_SECOND_RST;
			key_q[2] <= KEY_THIRD_RST;
			hold_q   <= LIGHT_HOLD_RST;
			gap_q    <= DIGIT_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_FIRST:  key_q[0] <= cfg_data[DIGIT_W-1:0];
				CFG_KEY_SECOND: key_q[1] <= cfg_data[DIGIT_W-1:0];
				CFG_KEY_THIRD:  key_q[2] <= cfg_data[DIGIT_W-1:0];
				CFG_LIGHT_HOLD: hold_q   <= cfg_data[TICK_W-1:0];
				CFG_DIGIT_GAP:  gap_q    <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	lacc_light u_light (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.hold     (hold_q),
		.light_on (light_on)
	);

	lacc_entry u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.gap      (gap_q),
		.key      (key_q),
		.entering (entering),
		.position (position),
		.evt      (evt)
	);

	lacc_alarm u_alarm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.evt     (evt),
		.armed   (armed),
		.siren   (siren),
		.code_ok (code_ok)
	);

	assign result_valid          = result_valid_q;
	assign result.light_on       = light_on;
	assign result.alarm_armed    = armed;
	assign result.siren_on       = siren;
	assign result.entering_code  = entering;
	assign result.digit_position = position;
	assign result.code_accepted  = code_ok;

	`LACC_ASSERT_NOW(a_siren_needs_armed, clk, arst_n, result.siren_on, result.alarm_armed,
		"siren on while alarm disarmed")
	`LACC_ASSERT_NOW(a_index_in_range, clk, arst_n, 1'b1, result.digit_position <= LAST_IDX,
		"digit index beyond last digit")
	`LACC_ASSERT_NOW(a_full_blocks_input, clk, arst_n,
		valid_s1 && result_valid_q && !result_ready, !item_ready,
		"input taken while stage and result are both full")
	`LACC_ASSERT_NEXT(a_state_holds, clk, arst_n, !advance, $stable(result),
		"result changed without a step")

endmodule

// File: dv/light_alarm_code_controller_test.sv
// Self-checking bench for the light, alarm and code entry controller.
// Needs lacc_pkg and the controller RTL; a scoreboard class predicts every result word.
module light_alarm_code_controller_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lacc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 40;
	localparam int PRESSURE_AT = 400;
	localparam int PRESSURE_CYCLES = 80;
	// no register lives at this index; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	class alarm_scoreboard;
		digit_t key[CODE_DIGITS];
		tick_t hold_ticks, gap_ticks;
		logic light_on, armed, siren, entering, code_ok, pressed_before;
		logic pres_light, pres_siren, button, start, press;
		idx_t position;
		digit_t digits[CODE_DIGITS];
		tick_t light_left, digit_left;
		result_t expected_q[$];
		int errors;

		function new();
			key[0] = KEY_FIRST_RST;
			key[1] = KEY_SECOND_RST;
			key[2] = KEY_THIRD_RST;
			hold_ticks = LIGHT_HOLD_RST;
			gap_ticks = DIGIT_GAP_RST;
			{light_on, armed, siren, entering, code_ok, pressed_before} = '0;
			{pres_light, pres_siren, button, start, press} = '0;
			position = '0;
			light_left = '0;
			digit_left = '0;
			foreach (digits[k]) digits[k] = '0;
			errors = 0;
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_KEY_FIRST:  key[0] = data[DIGIT_W-1:0];
				CFG_KEY_SECOND: key[1] = data[DIGIT_W-1:0];
				CFG_KEY_THIRD:  key[2] = data[DIGIT_W-1:0];
				CFG_LIGHT_HOLD: hold_ticks = data;
				CFG_DIGIT_GAP:  gap_ticks = data;
				default: ;
			endcase
		endfunction

		function bit code_matches();
			foreach (digits[k])
				if (digits[k] != key[k]) return 0;
			return 1;
		endfunction

		// Advance one step and queue the state it leaves behind.
		function void note_item(item_t w);
			result_t r;
			bit expired;
			if (w.presence_seen) begin
				pres_light = 1;
				pres_siren = 1;
			end
			if (w.button_pressed) button = 1;
			if (w.start_request) start = 1;
			if (w.digit_press) press = 1;
			if (light_left != 0) light_left--;
			if (digit_left != 0) digit_left--;

			if (!light_on) begin
				if (pres_light || button) begin
					light_on = 1;
					light_left = hold_ticks;
					pres_light = 0;
					button = 0;
				end
			end else if (pres_light && !button) begin
				light_left = hold_ticks;
				pres_light = 0;
			end else if (button || light_left == 0) begin
				light_on = 0;
				button = 0;
			end

			if (!armed) begin
				if (code_ok) begin
					armed = 1;
					code_ok = 0;
					pres_siren = 0;
				end
			end else if (pres_siren && !code_ok) begin
				siren = 1;
				pres_siren = 0;
			end else if (code_ok) begin
				armed = 0;
				code_ok = 0;
				siren = 0;
			end

			expired = (digit_left == 0);
			if (!entering) begin
				if (start) entering = 1;
			end else if (position < CODE_DIGITS && press) begin
				digits[position] = digit_t'((int'(digits[position]) + 1) % 10);
				digit_left = gap_ticks;
				pressed_before = 1;
				press = 0;
			end else if (position < LAST_IDX && expired && pressed_before) begin
				digit_left = gap_ticks;
				position++;
				pressed_before = 0;
			end else if (position >= LAST_IDX && expired) begin
				code_ok = code_matches();
				start = 0;
				foreach (digits[k]) digits[k] = '0;
				position = '0;
				entering = 0;
			end

			r.light_on = light_on;
			r.alarm_armed = armed;
			r.siren_on = siren;
			r.entering_code = entering;
			r.digit_position = position;
			r.code_accepted = code_ok;
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result word with none expected, actual %b", $time, got);
				return;
			end
			want = expected_q.pop_front();
			check_field("light_on", 2'(want.light_on), 2'(got.light_on));
			check_field("alarm_armed", 2'(want.alarm_armed), 2'(got.alarm_armed));
			check_field("siren_on", 2'(want.siren_on), 2'(got.siren_on));
			check_field("entering_code", 2'(want.entering_code), 2'(got.entering_code));
			check_field("digit_position", want.digit_position, got.digit_position);
			check_field("code_accepted", 2'(want.code_accepted), 2'(got.code_accepted));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	alarm_scoreboard board = new();
	int sent_count = 0;
	int cycles = 0;
	bit send_calm = 0;
	bit recv_calm = 0;
	bit pressure_done = 0;

	always #6 clk = ~clk;

	light_alarm_code_controller i_dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[light_alarm_code_controller] ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && result_ready) board.check_result(result);

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic item_t random_item(int pct_pres, int pct_btn, int pct_start, int pct_press);
		item_t w;
		w.presence_seen = ($urandom_range(0, 99) < pct_pres);
		w.button_pressed = ($urandom_range(0, 99) < pct_btn);
		w.start_request = ($urandom_range(0, 99) < pct_start);
		w.digit_press = ($urandom_range(0, 99) < pct_press);
		return w;
	endfunction

	// Result side: random stalls, plus one long hold-off to back the block up.
	initial begin
		int stall;
		stall = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
			if (!pressure_done && sent_count >= PRESSURE_AT) begin
				pressure_done = 1;
				result_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				stall = pick_gap(recv_calm);
			end
		end
	end

	// Call at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_item(item_t w);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		board.note_item(w);
		sent_count++;
		if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.load_reg(index, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] k0, logic [CFG_DATA_W-1:0] k1,
			logic [CFG_DATA_W-1:0] k2, logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] gap);
		write_reg(CFG_KEY_FIRST, k0);
		write_reg(CFG_KEY_SECOND, k1);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
		write_reg(CFG_KEY_THIRD, k2);
		write_reg(CFG_LIGHT_HOLD, hold);
		write_reg(CFG_DIGIT_GAP, gap);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every result word is back.
	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Start, then per digit a run of presses and a quiet stretch that closes it.
	task automatic enter_code(key_t targets);
		int presses, quiet;
		send_item(random_item(20, 10, 100, 0));
		for (int d = 0; d < CODE_DIGITS; d++) begin
			presses = (targets[d] == 0) ? 10 : int'(targets[d]);
			if ($urandom_range(0, 4) == 0) presses += 10;
			repeat (presses) send_item(random_item(15, 8, 3, 100));
			quiet = (board.gap_ticks == 0 ? 1 : int'(board.gap_ticks)) + $urandom_range(0, 1);
			// break the sequence now and then with a short pause
			if ($urandom_range(0, 9) == 0) quiet = $urandom_range(0, quiet);
			repeat (quiet) send_item(random_item(15, 8, 3, 0));
		end
	endtask

	task automatic run_phase(int budget, int pct_entry);
		int stop;
		key_t targets;
		stop = sent_count + budget;
		while (sent_count < stop) begin
			if ($urandom_range(0, 99) < pct_entry) begin
				for (int d = 0; d < CODE_DIGITS; d++)
					targets[d] = ($urandom_range(0, 9) < 6) ? board.key[d] :
						digit_t'($urandom_range(0, 9));
				enter_code(targets);
			end else begin
				repeat ($urandom_range(1, 8)) send_item(random_item(30, 20, 15, 25));
			end
		end
		drain();
	endtask

	initial begin
		// presence alone, button alone, all at once, and a button that switches the light off
		item_t opening_words[6];
		// key 1,1,1 with gap 1: enter it, arm, then trip the siren; hold 2 lets the light lapse
		item_t entry_words[12];
		opening_words = '{4'b0000, 4'b1000, 4'b0100, 4'b1111, 4'b0000, 4'b0100};
		entry_words = '{4'b0010, 4'b0001, 4'b0000, 4'b0001, 4'b0000, 4'b0001,
			4'b0000, 4'b0000, 4'b1000, 4'b0000, 4'b0000, 4'b0000};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_words[k]) send_item(opening_words[k]);
		drain();
		configure(1, 1, 1, 2, 1);
		foreach (entry_words[k]) send_item(entry_words[k]);
		drain();

		configure(0, 0, 0, 1, 1);
		run_phase(200, 70);
		configure(9, 9, 9, 255, 2);
		run_phase(250, 70);
		// keys above nine never match; zero hold and gap expire at once
		configure(8'h0f, 8'hfa, 8'h0c, 0, 0);
		run_phase(200, 70);
		configure(CFG_DATA_W'(KEY_FIRST_RST), CFG_DATA_W'(KEY_SECOND_RST),
			CFG_DATA_W'(KEY_THIRD_RST), LIGHT_HOLD_RST, DIGIT_GAP_RST);
		run_phase(300, 75);
		configure(CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(0, 9)),
			CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(1, 255)), 255);
		run_phase(120, 0);
		configure(CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(0, 9)),
			CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(1, 30)), 40);
		run_phase(150, 60);
		repeat (3) begin
			configure(CFG_DATA_W'($urandom_range(0, 11)), CFG_DATA_W'($urandom_range(0, 11)),
				CFG_DATA_W'($urandom_range(0, 11)), CFG_DATA_W'($urandom_range(1, 12)),
				CFG_DATA_W'($urandom_range(1, 5)));
			run_phase(200, 70);
		end

		drain();
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("[light_alarm_code_controller] OK");
		else
			$display("[light_alarm_code_controller] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lacc_pkg.sv
hw/rtl/lacc_light.sv
hw/rtl/lacc_entry.sv
hw/rtl/lacc_alarm.sv
hw/rtl/light_alarm_code_controller.sv
dv/light_alarm_code_controller_test.sv
